// File: rtl/md4_pkg.sv
// Shared types, constants and step tables for the MD4 digest core.
package md4_pkg;

	typedef logic [31:0] word_t;
	typedef logic [3:0][31:0] regs_t;

	// Command codes carried on the slave tuser
	typedef enum logic [1:0] {
		CMD_BEGIN  = 2'd0,
		CMD_ABSORB = 2'd1,
		CMD_FINISH = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_LEN,
		ST_EMIT,
		ST_ERR
	} state_t;

	// Where the sequencer goes once a block has been folded in
	typedef enum logic [1:0] {
		RET_IDLE,
		RET_LEN,
		RET_EMIT
	} cret_t;

	localparam word_t INIT_A = 32'h67452301;
	localparam word_t INIT_B = 32'hefcdab89;
	localparam word_t INIT_C = 32'h98badcfe;
	localparam word_t INIT_D = 32'h10325476;
	localparam word_t ROUND2_ADD = 32'o13240474631;
	localparam word_t ROUND3_ADD = 32'o15666365641;
	localparam logic [5:0] PAD_LIMIT = 6'd55;
	localparam logic [5:0] LAST_STEP = 6'd47;
	localparam logic [5:0] LAST_BYTE = 6'd63;

	// Message word used by a step: straight, transposed, then bit-reversed order
	function automatic logic [3:0] msg_index(input logic [5:0] step);
		logic [3:0] i;
		logic [3:0] r;
		i = step[3:0];
		case (step[5:4])
			2'd0:    r = i;
			2'd1:    r = {i[1:0], i[3:2]};
			2'd2:    r = {i[0], i[1], i[2], i[3]};
			default: r = i;
		endcase
		return r;
	endfunction

	// Left rotate amount of a step
	function automatic logic [4:0] rot_amount(input logic [5:0] step);
		logic [4:0] s;
		case ({step[5:4], step[1:0]})
			4'b0000: s = 5'd3;
			4'b0001: s = 5'd7;
			4'b0010: s = 5'd11;
			4'b0011: s = 5'd19;
			4'b0100: s = 5'd3;
			4'b0101: s = 5'd5;
			4'b0110: s = 5'd9;
			4'b0111: s = 5'd13;
			4'b1000: s = 5'd3;
			4'b1001: s = 5'd9;
			4'b1010: s = 5'd11;
			4'b1011: s = 5'd15;
			default: s = 5'd3;
		endcase
		return s;
	endfunction

endpackage

// File: rtl/md4_round.sv
// Shared MD4 step unit: one of the 48 compression steps per use.
module md4_round import md4_pkg::*; (
	input  regs_t       rr,
	input  logic [5:0]  step,
	input  word_t       x,
	output logic [1:0]  tgt,
	output word_t       result
);

	word_t a, b, c, d, fn, sum;
	logic [63:0] rot;
	logic [4:0] s;

	// Register roles rotate by one each step
	always_comb begin
		tgt = 2'(3'd4 - {1'b0, step[1:0]});
		a = rr[tgt];
		b = rr[2'(tgt + 2'd1)];
		c = rr[2'(tgt + 2'd2)];
		d = rr[2'(tgt + 2'd3)];
	end

	// Round function with its additive constant
	always_comb begin
		case (step[5:4])
			2'd0:    fn = (b & c) | (~b & d);
			2'd1:    fn = ((b & c) | (b & d) | (c & d)) + ROUND2_ADD;
			default: fn = (b ^ c ^ d) + ROUND3_ADD;
		endcase
	end

	// Sum then rotate left
	always_comb begin
		s = rot_amount(step);
		sum = a + fn + x;
		rot = {sum, sum} << s;
		result = rot[63:32];
	end

endmodule

// File: rtl/md4_message_digest_core.sv
// Top level of the byte-serial MD4 digest core: sequencer, block buffer and chaining words.
//
// Slave channel takes commands: tuser carries the command (begin, absorb, finish),
// tdata the message byte and its count of valid high bits. Master channel returns
// results: four digest words, word 0 first, tlast on the fourth, or one rejection
// transfer (tuser high, data zero, tlast high) for an absorb after finish or after
// a short byte.
// Begin and ordinary absorb transfers are taken without a stall. The absorb that fills
// a 64-byte block then holds tready low for one load, 48 steps through the single
// shared step unit and one fold into the chaining words.
// Finish takes a padding step, a length step and one block, or, where the padding
// spills into a second block, a padding step, a block, a length step and a second
// block, before the first digest word appears; finish after finish emits straight away.
// The step unit sets the rate: one step per cycle, 48 per block. Bytes are taken
// one per cycle, except while tready is held low for each block.
// One command is handled at a time; results wait, held stable, while the receiver
// keeps tready low, and no new command is taken until all have been transferred.
// Reset loads the standard chaining words and clears the counters and flags.
module md4_message_digest_core import md4_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // data_byte [7:0], bit_count [11:8], zero fill
	input  logic [1:0]  s_axis_tuser,  // cmd [1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // digest_word [31:0], word_index [33:32], zero fill
	output logic        m_axis_tlast,
	output logic        m_axis_tuser   // status [0]
);

	state_t      state_q, state_d;
	cret_t       ret_q;
	regs_t       chain_q;
	regs_t       rr_q;
	word_t       blk_q [16];
	logic [5:0]  pos_q;
	logic [5:0]  step_q;
	logic [63:0] total_q;
	logic        fin_q;
	logic        short_q;
	logic        two_q;
	logic [1:0]  idx_q;

	logic        in_xfer;
	logic        out_xfer;
	cmd_t        cmd;
	logic [7:0]  data_byte;
	logic [3:0]  bit_count;
	logic [3:0]  nb;
	logic [7:0]  masked;
	logic [7:0]  cur_byte;
	logic [7:0]  pad_mask;
	logic [7:0]  pad_byte;
	logic [1:0]  tgt;
	word_t       step_res;

	assign in_xfer   = s_axis_tvalid & s_axis_tready;
	assign out_xfer  = m_axis_tvalid & m_axis_tready;
	assign cmd       = cmd_t'(s_axis_tuser);
	assign data_byte = s_axis_tdata[7:0];
	assign bit_count = s_axis_tdata[11:8];

	// Valid bit count clamped to a byte, invalid low bits cleared
	always_comb begin
		nb = (bit_count > 4'd8) ? 4'd8 : bit_count;
		masked = data_byte & 8'(16'hFF00 >> nb);
	end

	// Padding byte: a 1 right after the last message bit
	always_comb begin
		cur_byte = 8'(blk_q[pos_q[5:2]] >> {pos_q[1:0], 3'b000});
		pad_mask = 8'h80 >> total_q[2:0];
		pad_byte = short_q ? (cur_byte | pad_mask) : 8'h80;
	end

	md4_round u_round (
		.rr     (rr_q),
		.step   (step_q),
		.x      (blk_q[msg_index(step_q)]),
		.tgt    (tgt),
		.result (step_res)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					case (cmd)
						CMD_ABSORB: begin
							if (fin_q || short_q)
								state_d = ST_ERR;
							else if (nb == 4'd8 && pos_q == LAST_BYTE)
								state_d = ST_LOAD;
						end
						CMD_FINISH: state_d = fin_q ? ST_EMIT : ST_PAD;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOAD:  state_d = ST_ROUND;
			ST_ROUND: if (step_q == LAST_STEP) state_d = ST_FOLD;
			ST_FOLD: begin
				case (ret_q)
					RET_LEN:  state_d = ST_LEN;
					RET_EMIT: state_d = ST_EMIT;
					default:  state_d = ST_IDLE;
				endcase
			end
			ST_PAD:   state_d = (pos_q > PAD_LIMIT) ? ST_LOAD : ST_LEN;
			ST_LEN:   state_d = ST_LOAD;
			ST_EMIT:  if (m_axis_tready && idx_q == 2'd3) state_d = ST_IDLE;
			ST_ERR:   if (m_axis_tready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Handshake and result outputs
	always_comb begin
		s_axis_tready = 1'b0;
		m_axis_tvalid = 1'b0;
		m_axis_tdata  = '0;
		m_axis_tlast  = 1'b0;
		m_axis_tuser  = 1'b0;
		case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_EMIT: begin
				m_axis_tvalid = 1'b1;
				m_axis_tdata  = {6'd0, idx_q, chain_q[idx_q]};
				m_axis_tlast  = (idx_q == 2'd3);
			end
			ST_ERR: begin
				m_axis_tvalid = 1'b1;
				m_axis_tlast  = 1'b1;
				m_axis_tuser  = 1'b1;
			end
			default: s_axis_tready = 1'b0;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Control registers: chaining words, counters, flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= {INIT_D, INIT_C, INIT_B, INIT_A};
			pos_q   <= '0;
			total_q <= '0;
			fin_q   <= 1'b0;
			short_q <= 1'b0;
			two_q   <= 1'b0;
			ret_q   <= RET_IDLE;
			step_q  <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (in_xfer && cmd == CMD_BEGIN) begin
						chain_q <= {INIT_D, INIT_C, INIT_B, INIT_A};
						pos_q   <= '0;
						total_q <= '0;
						fin_q   <= 1'b0;
						short_q <= 1'b0;
					end else if (in_xfer && cmd == CMD_ABSORB && !fin_q && !short_q &&
						nb != 4'd0) begin
						total_q <= total_q + 64'(nb);
						ret_q   <= RET_IDLE;
						if (nb != 4'd8)
							short_q <= 1'b1;
						else
							pos_q <= pos_q + 6'd1;
					end
				end
				ST_LOAD:  step_q <= '0;
				ST_ROUND: step_q <= step_q + 6'd1;
				ST_FOLD: begin
					for (int k = 0; k < 4; k++)
						chain_q[k] <= chain_q[k] + rr_q[k];
					if (ret_q == RET_EMIT) begin
						fin_q <= 1'b1;
						pos_q <= '0;
					end
				end
				ST_PAD: begin
					two_q <= (pos_q > PAD_LIMIT);
					ret_q <= (pos_q > PAD_LIMIT) ? RET_LEN : RET_EMIT;
				end
				ST_LEN:  ret_q <= RET_EMIT;
				ST_EMIT: if (out_xfer) idx_q <= idx_q + 2'd1;
				default: idx_q <= idx_q;
			endcase
		end
	end

	// Working registers of the compression
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD)
			rr_q <= chain_q;
		else if (state_q == ST_ROUND)
			rr_q[tgt] <= step_res;
	end

	// Block buffer: byte writes on absorb, padding and length on finish
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_xfer && cmd == CMD_ABSORB && !fin_q && !short_q &&
			nb != 4'd0) begin
			for (int j = 0; j < 4; j++)
				if (pos_q[1:0] == 2'(j))
					blk_q[pos_q[5:2]][j*8 +: 8] <= masked;
		end else if (state_q == ST_PAD) begin
			for (int w = 0; w < 16; w++)
				for (int j = 0; j < 4; j++) begin
					if (6'(w*4 + j) == pos_q)
						blk_q[w][j*8 +: 8] <= pad_byte;
					else if (6'(w*4 + j) > pos_q)
						blk_q[w][j*8 +: 8] <= 8'd0;
				end
		end else if (state_q == ST_LEN) begin
			if (two_q)
				for (int w = 0; w < 14; w++)
					blk_q[w] <= '0;
			blk_q[14] <= total_q[31:0];
			blk_q[15] <= total_q[63:32];
		end
	end

`ifndef SYNTH
	// No command is taken while a result is on offer
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid)
		else $error("command accepted while a result is pending");

	// The step counter never runs past the last step
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (step_q <= LAST_STEP))
		else $error("round step out of range");

	// A rejection is a single transfer closing the run
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == 40'd0))
		else $error("malformed rejection result");

	// After the final fold the digest is marked finished
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FOLD && ret_q == RET_EMIT) |=> (fin_q && pos_q == 6'd0))
		else $error("finish did not set the finished flag");
`endif

endmodule
